// ===== sv/jdd_pkg.sv =====
// Shared types and constants for the joystick direction detector.
package jdd_pkg;

    // Direction lanes, in report order.
    localparam int DIRS       = 4;
    localparam int DIR_RIGHT  = 0;
    localparam int DIR_LEFT   = 1;
    localparam int DIR_UP     = 2;
    localparam int DIR_DOWN   = 3;

    // Widths of the timestamp and the millisecond timing registers.
    localparam int TIME_W     = 32;
    localparam int MS_CFG_W   = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_MS   = 3'd5;

    // Reset values of the registers.
    localparam int RST_RIGHT_THR = 600;
    localparam int RST_LEFT_THR  = 400;
    localparam int RST_UP_THR    = 600;
    localparam int RST_DOWN_THR  = 400;
    localparam logic [MS_CFG_W-1:0] RST_CLICK_MS = 16'd50;
    localparam logic [MS_CFG_W-1:0] RST_HOLD_MS  = 16'd500;

    // Item modes.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // What one lane reports for the current item.
    typedef struct packed {
        logic press;
        logic hold;
    } t_lane_report;

endpackage

// ===== sv/jdd_if.sv =====
// Input and output channel interfaces of the joystick direction detector.
interface jdd_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic [31:0]            now_ms;

    modport source (output valid, mode, x_sample, y_sample, now_ms, input ready);
    modport sink   (input valid, mode, x_sample, y_sample, now_ms, output ready);
endinterface

interface jdd_out_if;
    logic valid;
    logic ready;
    logic right_press;
    logic left_press;
    logic up_press;
    logic down_press;
    logic right_repeat;
    logic left_repeat;
    logic up_repeat;
    logic down_repeat;

    modport source (output valid, right_press, left_press, up_press, down_press,
                    right_repeat, left_repeat, up_repeat, down_repeat, input ready);
    modport sink   (input valid, right_press, left_press, up_press, down_press,
                    right_repeat, left_repeat, up_repeat, down_repeat, output ready);
endinterface

// ===== sv/jdd_lane.sv =====
// One direction lane: threshold compare, debounce machine and latches.
module jdd_lane
    import jdd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10,
    parameter bit ABOVE       = 1'b1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_mode,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_threshold,
    input  logic [TIME_W-1:0]      i_now_ms,
    input  logic [MS_CFG_W-1:0]    i_click_ms,
    input  logic [MS_CFG_W-1:0]    i_hold_ms,
    output t_lane_report           o_report
);

    logic              r_engaged, n_engaged;
    logic [TIME_W-1:0] r_stamp, n_stamp;
    logic              r_press, n_press;
    logic              r_hold, n_hold;

    logic              deflected;
    logic [TIME_W-1:0] elapsed;
    logic              over_click;
    logic              over_hold;

    // Deadzone compare against this lane's threshold.
    assign deflected = ABOVE ? (i_sample > i_threshold) : (i_sample < i_threshold);

    // Wrapping time since the last event of this direction.
    assign elapsed    = i_now_ms - r_stamp;
    assign over_click = elapsed > {{(TIME_W-MS_CFG_W){1'b0}}, i_click_ms};
    assign over_hold  = elapsed > {{(TIME_W-MS_CFG_W){1'b0}}, i_hold_ms};

    // Next state. An engage restamps, so a hold cannot fire in the same item;
    // release needs the direction to be back in the deadzone.
    always_comb begin
        n_engaged = r_engaged;
        n_stamp   = r_stamp;
        n_press   = r_press;
        n_hold    = r_hold;
        if (i_mode == MODE_READ) begin
            n_press = 1'b0;
            n_hold  = 1'b0;
        end else begin
            priority if (deflected && !r_engaged && over_click) begin
                n_stamp   = i_now_ms;
                n_engaged = 1'b1;
                n_press   = 1'b1;
            end else if (deflected && r_engaged && over_hold) begin
                n_stamp = i_now_ms;
                n_hold  = 1'b1;
            end else if (!deflected && r_engaged && over_click) begin
                n_stamp   = i_now_ms;
                n_engaged = 1'b0;
                n_press   = 1'b0;
            end else begin
                n_stamp = r_stamp;
            end
        end
    end

    // A read reports the latches before clearing; a sample reports after update.
    assign o_report.press = (i_mode == MODE_READ) ? r_press : n_press;
    assign o_report.hold  = (i_mode == MODE_READ) ? r_hold  : n_hold;

    // Lane state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engaged <= 1'b0;
            r_stamp   <= '0;
            r_press   <= 1'b0;
            r_hold    <= 1'b0;
        end else if (i_accept) begin
            r_engaged <= n_engaged;
            r_stamp   <= n_stamp;
            r_press   <= n_press;
            r_hold    <= n_hold;
        end
    end

endmodule

// ===== sv/jdd_merge.sv =====
// Merging stage: gathers the lane reports into the registered result beat.
module jdd_merge
    import jdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_lane_report      i_reports [DIRS],
    output logic              o_free,
    jdd_out_if.source         o_out
);

    logic               r_valid;
    t_lane_report [DIRS-1:0] r_data;

    // The register can take a new beat when empty or being drained now.
    assign o_free = !r_valid || o_out.ready;

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            for (int d = 0; d < DIRS; d++) begin
                r_data[d] <= i_reports[d];
            end
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.right_press  = r_data[DIR_RIGHT].press;
    assign o_out.left_press   = r_data[DIR_LEFT].press;
    assign o_out.up_press     = r_data[DIR_UP].press;
    assign o_out.down_press   = r_data[DIR_DOWN].press;
    assign o_out.right_repeat = r_data[DIR_RIGHT].hold;
    assign o_out.left_repeat  = r_data[DIR_LEFT].hold;
    assign o_out.up_repeat    = r_data[DIR_UP].hold;
    assign o_out.down_repeat  = r_data[DIR_DOWN].hold;

endmodule

// ===== sv/joystick_deadzone_direction_detect.sv =====
// Top level of the joystick direction detector with deadzone, debounce and hold.
// The block takes one item per clock cycle while output ready is high and
// delivers its result beat in the cycle after acceptance from an output
// register. Four direction lanes run in parallel on each item, each doing one
// threshold compare, one 32-bit wrapping subtraction of its event stamp and two
// compares; a merging register collects the eight latches. Input ready is high
// whenever the output register is empty or its beat is being taken in the same
// cycle, so the output ready is the only thing that sets the rate. A sample
// item (mode 0) updates the debounce machines and reports the latches after the
// update; a read item (mode 1) reports the latches and then clears them.
// Configuration writes should be made only while no beat is in flight.
module joystick_deadzone_direction_detect
    import jdd_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    jdd_in_if.sink                i_in,
    jdd_out_if.source             o_out
);

    logic [SAMPLE_BITS-1:0] r_thr [DIRS];
    logic [MS_CFG_W-1:0]    r_click_ms;
    logic [MS_CFG_W-1:0]    r_hold_ms;

    logic                   free;
    logic                   accept;
    t_lane_report           reports [DIRS];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr[DIR_RIGHT] <= SAMPLE_BITS'(RST_RIGHT_THR);
            r_thr[DIR_LEFT]  <= SAMPLE_BITS'(RST_LEFT_THR);
            r_thr[DIR_UP]    <= SAMPLE_BITS'(RST_UP_THR);
            r_thr[DIR_DOWN]  <= SAMPLE_BITS'(RST_DOWN_THR);
            r_click_ms       <= RST_CLICK_MS;
            r_hold_ms        <= RST_HOLD_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RIGHT_THR: r_thr[DIR_RIGHT] <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_LEFT_THR:  r_thr[DIR_LEFT]  <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_UP_THR:    r_thr[DIR_UP]    <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_DOWN_THR:  r_thr[DIR_DOWN]  <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_CLICK_MS:  r_click_ms       <= i_cfg_data[MS_CFG_W-1:0];
                CFG_HOLD_MS:   r_hold_ms        <= i_cfg_data[MS_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input handshake.
    assign i_in.ready = free;
    assign accept     = i_in.valid && free;

    // One lane per direction; right and left look at X, up and down at Y.
    for (genvar d = 0; d < DIRS; d++) begin : g_lane
        localparam bit ABOVE = (d == DIR_RIGHT) || (d == DIR_UP);
        logic [SAMPLE_BITS-1:0] lane_sample;

        assign lane_sample = ((d == DIR_RIGHT) || (d == DIR_LEFT)) ? i_in.x_sample
                                                                   : i_in.y_sample;

        jdd_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .ABOVE       (ABOVE)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_accept    (accept),
            .i_mode      (i_in.mode),
            .i_sample    (lane_sample),
            .i_threshold (r_thr[d]),
            .i_now_ms    (i_in.now_ms),
            .i_click_ms  (r_click_ms),
            .i_hold_ms   (r_hold_ms),
            .o_report    (reports[d])
        );
    end

    // Merge the lane reports into the output beat.
    jdd_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_reports (reports),
        .o_free    (free),
        .o_out     (o_out)
    );

    // Every accepted item leaves a result beat in the output register.
    a_accept_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_out.valid)
        else $error("accepted item produced no result beat");

    // An empty output register never stalls the input.
    a_empty_is_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled while output register empty");

    // Two reads back to back: the second one sees every latch cleared.
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.mode == MODE_READ && $past(i_rst_n) &&
         $past(accept && i_in.mode == MODE_READ))
        |=> (!o_out.right_press && !o_out.left_press && !o_out.up_press &&
             !o_out.down_press && !o_out.right_repeat && !o_out.left_repeat &&
             !o_out.up_repeat && !o_out.down_repeat))
        else $error("latches not cleared by read");

endmodule

// ===== sim/joystick_deadzone_direction_detect_tb.sv =====
// Self-checking testbench for the joystick direction detector with deadzone and hold.
module joystick_deadzone_direction_detect_tb;
    import jdd_pkg::*;

    localparam int SB          = 10;
    localparam int SAMPLE_MAX  = (1 << SB) - 1;
    localparam int STALL_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 275;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_HOLD_MS + 3'd1;

    // One input beat and the eight latches that one result beat carries.
    typedef struct packed {
        logic          mode;
        logic [SB-1:0] x;
        logic [SB-1:0] y;
        logic [31:0]   now;
    } t_joy_item;

    typedef struct packed {
        logic [DIRS-1:0] press;
        logic [DIRS-1:0] hold;
    } t_latch_set;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    jdd_in_if #(.SAMPLE_BITS(SB)) in_ch ();
    jdd_out_if                    out_ch ();

    joystick_deadzone_direction_detect #(
        .SAMPLE_BITS(SB)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor copy of the registers and of the four debounce lanes.
    logic [SB-1:0]       thr_right, thr_left, thr_up, thr_down;
    logic [MS_CFG_W-1:0] click_ms, hold_ms;
    logic [DIRS-1:0]     lane_engaged, press_q, hold_q;
    logic [31:0]         lane_stamp [DIRS];

    t_joy_item  stick_items [$];
    t_latch_set expected_latches [$];

    logic [31:0] stick_now;
    bit          no_idle;
    int          mismatch_count;
    int          cycle_count;
    int          stall_asks, stall_done;
    logic        recv_hold_off;
    string       lane_name [DIRS] = '{"right", "left", "up", "down"};

    // Debounce, hold and read-clear behavior for one accepted beat.
    function automatic t_latch_set predict_latches(input t_joy_item it);
        logic [DIRS-1:0] defl;
        logic [31:0]     gap;
        t_latch_set      r;
        int              d;
        if (it.mode == MODE_SAMPLE) begin
            defl[DIR_RIGHT] = it.x > thr_right;
            defl[DIR_LEFT]  = it.x < thr_left;
            defl[DIR_UP]    = it.y > thr_up;
            defl[DIR_DOWN]  = it.y < thr_down;
            for (d = 0; d < DIRS; d++) begin
                gap = it.now - lane_stamp[d];
                if (defl[d] && !lane_engaged[d] && gap > {16'd0, click_ms}) begin
                    lane_stamp[d]   = it.now;
                    lane_engaged[d] = 1'b1;
                    press_q[d]      = 1'b1;
                end
                // A fresh engage restamps, so the hold test sees no elapsed time.
                gap = it.now - lane_stamp[d];
                if (defl[d] && lane_engaged[d] && gap > {16'd0, hold_ms}) begin
                    lane_stamp[d] = it.now;
                    hold_q[d]     = 1'b1;
                end
                gap = it.now - lane_stamp[d];
                if (!defl[d] && lane_engaged[d] && gap > {16'd0, click_ms}) begin
                    lane_stamp[d]   = it.now;
                    lane_engaged[d] = 1'b0;
                    press_q[d]      = 1'b0;
                end
            end
        end
        r.press = press_q;
        r.hold  = hold_q;
        if (it.mode == MODE_READ) begin
            press_q = '0;
            hold_q  = '0;
        end
        return r;
    endfunction

    // Wait drawn for each beat on either side of the block.
    function automatic int draw_wait();
        if (no_idle || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // Axis reading that lands below, between, on or above the two thresholds.
    function automatic logic [SB-1:0] pick_axis(input int lo_thr, input int hi_thr);
        int v;
        case ($urandom_range(0, 5))
            0: v = (hi_thr >= SAMPLE_MAX) ? SAMPLE_MAX : $urandom_range(hi_thr + 1, SAMPLE_MAX);
            1: v = (lo_thr == 0) ? 0 : $urandom_range(0, lo_thr - 1);
            2: v = $urandom_range(lo_thr, hi_thr);
            3: v = hi_thr + $urandom_range(0, 2) - 1;
            4: v = lo_thr + $urandom_range(0, 2) - 1;
            default: v = $urandom_range(0, SAMPLE_MAX);
        endcase
        return v[SB-1:0];
    endfunction

    // Timestamp advance scaled to the current click and hold times.
    function automatic logic [31:0] time_step();
        int c;
        int h;
        c = int'(click_ms);
        h = int'(hold_ms);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, c + 2);
            4, 5, 6:    return $urandom_range(c, c + h + 2);
            7, 8:       return $urandom_range(h, h + h / 4 + 2);
            default:    return $urandom;
        endcase
    endfunction

    task automatic push_item(input logic mode, input logic [SB-1:0] x, input logic [SB-1:0] y,
                             input logic [31:0] now);
        t_joy_item it;
        it.mode = mode;
        it.x    = x;
        it.y    = y;
        it.now  = now;
        stick_items.push_back(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_RIGHT_THR: thr_right = val[SB-1:0];
            CFG_LEFT_THR:  thr_left  = val[SB-1:0];
            CFG_UP_THR:    thr_up    = val[SB-1:0];
            CFG_DOWN_THR:  thr_down  = val[SB-1:0];
            CFG_CLICK_MS:  click_ms  = val;
            CFG_HOLD_MS:   hold_ms   = val;
            default: ;
        endcase
    endtask

    // Writes all six registers plus an unused index, which must change nothing.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] r, l, u, dn, click, hold);
        write_reg(CFG_RIGHT_THR, r);
        write_reg(CFG_LEFT_THR, l);
        write_reg(CFG_UP_THR, u);
        write_reg(CFG_DOWN_THR, dn);
        write_reg(CFG_CLICK_MS, click);
        write_reg(CFG_HOLD_MS, hold);
        write_reg(CFG_SPARE_IDX + 3'($urandom_range(0, 1)), 16'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (stick_items.size() != 0 || in_ch.valid || expected_latches.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Mostly held stick positions with rising time, plus reads and jittered samples.
    task automatic random_phase(input int n);
        int left_items;
        int run;
        int i;
        logic [SB-1:0] x, y;
        left_items = n;
        while (left_items > 0) begin
            x = pick_axis(int'(thr_left), int'(thr_right));
            y = pick_axis(int'(thr_down), int'(thr_up));
            run = $urandom_range(1, 8);
            for (i = 0; i < run && left_items > 0; i++) begin
                if ($urandom_range(0, 99) < 15) begin
                    push_item(MODE_READ, SB'($urandom), SB'($urandom), $urandom);
                end else begin
                    stick_now = stick_now + time_step();
                    if ($urandom_range(0, 9) == 0)
                        push_item(MODE_SAMPLE, SB'($urandom), SB'($urandom), stick_now);
                    else
                        push_item(MODE_SAMPLE, x, y, stick_now);
                end
                left_items--;
            end
        end
    endtask

    // Input driver: offers queued beats with a random gap after each one.
    t_joy_item drv_item;
    int        send_wait;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                expected_latches.push_back(predict_latches(drv_item));
            if (!in_ch.valid || in_ch.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_ch.valid <= 1'b0;
                end else if (stick_items.size() > 0) begin
                    drv_item = stick_items.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.mode     <= drv_item.mode;
                    in_ch.x_sample <= drv_item.x;
                    in_ch.y_sample <= drv_item.y;
                    in_ch.now_ms   <= drv_item.now;
                    send_wait = draw_wait();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each result beat and paces ready.
    t_latch_set mon_got, mon_want;
    int         recv_wait;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                mon_got.press[DIR_RIGHT] = out_ch.right_press;
                mon_got.press[DIR_LEFT]  = out_ch.left_press;
                mon_got.press[DIR_UP]    = out_ch.up_press;
                mon_got.press[DIR_DOWN]  = out_ch.down_press;
                mon_got.hold[DIR_RIGHT]  = out_ch.right_repeat;
                mon_got.hold[DIR_LEFT]   = out_ch.left_repeat;
                mon_got.hold[DIR_UP]     = out_ch.up_repeat;
                mon_got.hold[DIR_DOWN]   = out_ch.down_repeat;
                if (expected_latches.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Unexpected result beat: press %b hold %b",
                                 mon_got.press, mon_got.hold);
                end else begin
                    mon_want = expected_latches.pop_front();
                    for (int d = 0; d < DIRS; d++) begin
                        if (mon_got.press[d] !== mon_want.press[d]) begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("%s_press: expected %b, actual %b", lane_name[d],
                                         mon_want.press[d], mon_got.press[d]);
                        end
                        if (mon_got.hold[d] !== mon_want.hold[d]) begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("%s_repeat: expected %b, actual %b", lane_name[d],
                                         mon_want.hold[d], mon_got.hold[d]);
                        end
                    end
                end
                recv_wait = draw_wait();
            end
            if (recv_hold_off) begin
                out_ch.ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the output register fills and input ready drops.
    always begin
        wait (stall_asks != stall_done);
        @(posedge i_clk);
        recv_hold_off <= 1'b1;
        repeat (STALL_CYCLES) @(posedge i_clk);
        recv_hold_off <= 1'b0;
        stall_done++;
    end

    // Run watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_RIGHT_THR;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_SAMPLE;
        in_ch.x_sample = '0;
        in_ch.y_sample = '0;
        in_ch.now_ms   = '0;
        out_ch.ready   = 1'b0;
        recv_hold_off  = 1'b0;
        stall_asks     = 0;
        stall_done     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        no_idle        = 1'b0;

        // Predictor state after reset.
        thr_right    = SB'(RST_RIGHT_THR);
        thr_left     = SB'(RST_LEFT_THR);
        thr_up       = SB'(RST_UP_THR);
        thr_down     = SB'(RST_DOWN_THR);
        click_ms     = RST_CLICK_MS;
        hold_ms      = RST_HOLD_MS;
        lane_engaged = '0;
        press_q      = '0;
        hold_q       = '0;
        for (int d = 0; d < DIRS; d++)
            lane_stamp[d] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset values, debounce, hold boundary, thresholds, wrap.
        push_item(MODE_READ,   10'd1023, 10'd1023, 32'hFFFF_FFFF);
        push_item(MODE_SAMPLE, 10'd1023, 10'd1023, 32'd10);
        push_item(MODE_SAMPLE, 10'd1023, 10'd0,    32'd51);
        push_item(MODE_SAMPLE, 10'd1023, 10'd0,    32'd551);
        push_item(MODE_SAMPLE, 10'd1023, 10'd0,    32'd552);
        push_item(MODE_READ,   10'd0,    10'd0,    32'd0);
        push_item(MODE_SAMPLE, 10'd0,    10'd1023, 32'd553);
        push_item(MODE_SAMPLE, 10'd0,    10'd1023, 32'd603);
        push_item(MODE_SAMPLE, 10'd600,  10'd400,  32'd700);
        push_item(MODE_SAMPLE, 10'd601,  10'd399,  32'd800);
        push_item(MODE_SAMPLE, 10'd400,  10'd600,  32'd900);
        push_item(MODE_SAMPLE, 10'd399,  10'd601,  32'd1000);
        push_item(MODE_READ,   10'd512,  10'd512,  32'd1001);
        push_item(MODE_SAMPLE, 10'd512,  10'd512,  32'hFFFF_FFF0);
        push_item(MODE_SAMPLE, 10'd1023, 10'd1023, 32'h0000_0030);
        push_item(MODE_READ,   10'd0,    10'd1023, 32'h0000_0031);
        wait_idle();

        // Directed: engage and hold on successive beats with zero click and hold times.
        apply_settings(16'd600, 16'd400, 16'd600, 16'd400, 16'd0, 16'd0);
        push_item(MODE_SAMPLE, 10'd1023, 10'd1023, 32'd2000);
        push_item(MODE_SAMPLE, 10'd1023, 10'd1023, 32'd2001);
        push_item(MODE_SAMPLE, 10'd1023, 10'd1023, 32'd2001);
        push_item(MODE_READ,   10'd1023, 10'd1023, 32'd2001);
        push_item(MODE_SAMPLE, 10'd512,  10'd512,  32'd2002);
        push_item(MODE_READ,   10'd512,  10'd512,  32'd2002);
        wait_idle();
        stick_now = 32'd3000;

        // Random phases over several settings, extremes among them.
        apply_settings(16'd600, 16'd400, 16'd600, 16'd400, 16'd50, 16'd500);
        random_phase(ITEMS_PER_PHASE);
        wait_idle();

        no_idle = 1'b1;
        apply_settings(16'd1023, 16'd0, 16'd0, 16'd1023, 16'd0, 16'd0);
        random_phase(ITEMS_PER_PHASE);
        wait_idle();
        no_idle = 1'b0;

        apply_settings(16'd0, 16'd1023, 16'd1023, 16'd0, 16'hFFFF, 16'hFFFF);
        random_phase(ITEMS_PER_PHASE);
        wait_idle();

        // Wide threshold data must be cut to the sample width; receiver stalls long.
        apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom_range(0, 200)), 16'($urandom_range(0, 1000)));
        stall_asks++;
        random_phase(ITEMS_PER_PHASE);
        wait_idle();

        apply_settings(16'($urandom_range(512, 800)), 16'($urandom_range(200, 512)),
                       16'($urandom_range(512, 800)), 16'($urandom_range(200, 512)),
                       16'($urandom_range(1, 100)), 16'($urandom_range(100, 600)));
        random_phase(ITEMS_PER_PHASE);
        wait_idle();

        apply_settings(16'd700, 16'd300, 16'd700, 16'd300, 16'd0, 16'hFFFF);
        random_phase(ITEMS_PER_PHASE);
        wait_idle();

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_latches.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
